// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the jitter buffer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the asynchronous reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assertion that must hold at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: rtl/core/fjb_pkg.sv
// ----------------------------------------------------------------------------
// fjb_pkg
// Types and constants shared by the frame jitter buffer modules.
// ----------------------------------------------------------------------------
package fjb_pkg;

  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned LIMIT_W    = 5;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_TOLERANCE = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 5'd16;
  localparam logic [COUNT_W-1:0] TOLERANCE_RESET = 16'd3;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_FLUSH = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]          action;
    logic [HANDLE_W-1:0] packet_handle;
  } in_item_t;

  typedef struct packed {
    logic                emit_packet;
    logic                emit_empty;
    logic [HANDLE_W-1:0] out_handle;
    logic                discarded;
    logic [LIMIT_W-1:0]  occupancy;
    logic [COUNT_W-1:0]  underrun_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

// File: rtl/core/fjb_stream_if.sv
// ----------------------------------------------------------------------------
// fjb_stream_if
// Valid/ready channel carrying one payload of a configurable type.
// ----------------------------------------------------------------------------
interface fjb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/fjb_ram.sv
// ----------------------------------------------------------------------------
// fjb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fjb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/fjb_ctrl.sv
// ----------------------------------------------------------------------------
// fjb_ctrl
// Sequencer: takes one transaction, runs it through the datapath, holds
// the result until the sink takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fjb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fjb_pkg::cmd_t cmd_o
);

  fjb_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fjb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fjb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = fjb_pkg::ST_EXEC;
        end
      end
      fjb_pkg::ST_EXEC: begin
        state_d = fjb_pkg::ST_RESP;
      end
      fjb_pkg::ST_RESP: begin
        if (out_ready_i) begin
          state_d = fjb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fjb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    unique case (state_q)
      fjb_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      fjb_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      fjb_pkg::ST_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  `ASSERT_RST(a_capture_then_exec, clk_i, rst_ni, cmd_o.capture |=> cmd_o.exec, "no exec after capture")
  `ASSERT_ALWAYS(a_no_overlap, clk_i, !(out_valid_o && in_ready_o), "input taken while result pending")
  `ASSERT_RST(a_exec_then_resp, clk_i, rst_ni, cmd_o.exec |=> out_valid_o, "result not presented after exec")

endmodule

// File: rtl/core/fjb_datapath.sv
// ----------------------------------------------------------------------------
// fjb_datapath
// FIFO pointers, fill level, underrun counter, configuration registers and
// the result register of the jitter buffer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fjb_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fjb_pkg::cmd_t                    cmd_i,
  input  fjb_pkg::in_item_t                in_data_i,
  input  logic                             cfg_we_i,
  input  logic [fjb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fjb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output fjb_pkg::out_item_t               out_data_o
);

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = (FILL_W > fjb_pkg::LIMIT_W) ? FILL_W : fjb_pkg::LIMIT_W;
  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(DEPTH - 1);
  localparam logic [CMP_W-1:0] DepthC  = CMP_W'(DEPTH);

  logic [1:0]                     act_q;
  logic [fjb_pkg::HANDLE_W-1:0]   handle_q;
  logic [PTR_W-1:0]               rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]               wr_ptr_q, wr_ptr_d;
  logic [FILL_W-1:0]              fill_q, fill_d;
  logic [fjb_pkg::COUNT_W-1:0]    under_q, under_d, under_inc;
  logic [fjb_pkg::LIMIT_W-1:0]    limit_q;
  logic [fjb_pkg::COUNT_W-1:0]    tol_q;
  logic [CMP_W-1:0]               limit_eff;
  logic                           ram_we;
  logic [fjb_pkg::HANDLE_W-1:0]   ram_rdata;
  fjb_pkg::out_item_t             res;
  fjb_pkg::out_item_t             out_q;

  // The store is read every cycle at the head pointer; the data is valid in
  // the exec cycle because the pointer only moves at exec.
  fjb_ram #(
    .WIDTH (fjb_pkg::HANDLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (handle_q),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  assign limit_eff = (CMP_W'(limit_q) > DepthC) ? DepthC : CMP_W'(limit_q);
  assign under_inc = (under_q == '1) ? under_q : under_q + 1'b1;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    under_d  = under_q;
    ram_we   = 1'b0;
    res      = '0;
    unique case (fjb_pkg::action_e'(act_q))
      fjb_pkg::ACT_PUSH: begin
        if (CMP_W'(fill_q) >= limit_eff) begin
          res.discarded = 1'b1;
        end else begin
          ram_we   = cmd_i.exec;
          wr_ptr_d = ptr_next(wr_ptr_q);
          fill_d   = fill_q + 1'b1;
        end
      end
      fjb_pkg::ACT_TICK: begin
        if (fill_q != '0) begin
          res.emit_packet = 1'b1;
          res.out_handle  = ram_rdata;
          rd_ptr_d        = ptr_next(rd_ptr_q);
          fill_d          = fill_q - 1'b1;
        end else begin
          under_d        = under_inc;
          res.emit_empty = (under_inc > tol_q);
        end
      end
      fjb_pkg::ACT_CLEAR: begin
        under_d = '0;
      end
      fjb_pkg::ACT_FLUSH: begin
        fill_d   = '0;
        rd_ptr_d = '0;
        wr_ptr_d = '0;
      end
      default: begin
        res = '0;
      end
    endcase
    res.occupancy      = fjb_pkg::LIMIT_W'(fill_d);
    res.underrun_count = under_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
      under_q  <= '0;
      limit_q  <= fjb_pkg::LIMIT_RESET;
      tol_q    <= fjb_pkg::TOLERANCE_RESET;
    end else begin
      if (cmd_i.exec) begin
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
        fill_q   <= fill_d;
        under_q  <= under_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fjb_pkg::REG_BUFFER_LIMIT:   limit_q <= cfg_data_i[fjb_pkg::LIMIT_W-1:0];
          fjb_pkg::REG_DROP_TOLERANCE: tol_q   <= cfg_data_i;
          default:                     tol_q   <= tol_q;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q    <= in_data_i.action;
      handle_q <= in_data_i.packet_handle;
    end
    if (cmd_i.exec) begin
      out_q <= res;
    end
  end

  assign out_data_o = out_q;

  `ASSERT_RST(a_fill_bounded, clk_i, rst_ni, CMP_W'(fill_q) <= DepthC, "fill level above depth")
  `ASSERT_RST(a_empty_ptrs, clk_i, rst_ni, (fill_q == '0) |-> (rd_ptr_q == wr_ptr_q), "empty with pointers apart")
  `ASSERT_RST(a_emit_excl, clk_i, rst_ni, cmd_i.exec |-> !(res.emit_packet && res.emit_empty), "packet and empty frame together")

endmodule

// File: rtl/core/frame_jitter_buffer_with_drop_count_top.sv
// Flow: an accepted transaction runs in the exec state, which registers its result, and the
// result is then held valid in the respond state until the sink takes it.
// Ordering: a new transaction is accepted only after the sink has taken the previous result;
// this is set by the controller's idle/exec/respond sequence around the registered store read.
// Reset: pointers, fill level and underrun count clear, buffer_limit returns to 16 and
// drop_tolerance to 3; the packet store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// frame_jitter_buffer_with_drop_count_top
// Bounded FIFO of packet handles between a bursty producer and a periodic
// consumer, with a saturating underrun counter that turns into empty frames.
// ----------------------------------------------------------------------------
module frame_jitter_buffer_with_drop_count_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fjb_stream_if.sink                     in_i,
  fjb_stream_if.source                   out_o,
  input  logic                           cfg_we_i,
  input  logic [fjb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fjb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Command bundle from the controller into the datapath.
  fjb_pkg::cmd_t      cmd;
  logic               in_ready;
  logic               out_valid;
  fjb_pkg::out_item_t out_data;

  // The controller accepts a transaction only while idle, runs it for one
  // exec cycle and then holds the result until the sink takes it.
  fjb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // The datapath owns the buffer state: the handle store, the FIFO pointers, the
  // fill level, the underrun counter and both configuration registers.
  // Configuration writes are taken at any cycle; the user must issue them only
  // while no transaction is in flight, which the block itself does not enforce.
  fjb_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_i.data),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data)
  );

  assign in_i.ready = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule
